>>> hw/rtl/sbim_pkg.sv
// Shared types, constants and helpers for the spatial bin index mapper.
`default_nettype none

package sbim_pkg;

    localparam int BIN_INDEX_BITS    = 10;
    localparam int CORDIC_ITERATIONS = 20;
    localparam int COORD_BITS        = 32;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int DIV_DVD_BITS      = COORD_BITS + BIN_INDEX_BITS;
    localparam int DIV_CNT_BITS      = $clog2(DIV_DVD_BITS);
    localparam int SQRT_CNT_BITS     = $clog2(COORD_BITS);
    localparam int CD_CNT_BITS       = $clog2(CORDIC_ITERATIONS);
    localparam int CD_W              = COORD_BITS + 3;
    localparam int ACC_W             = COORD_BITS + 2;

    localparam logic [3*BIN_INDEX_BITS-1:0] BINS_RESET = {3{BIN_INDEX_BITS'(1)}};

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RGN_X, REG_RGN_Y, REG_RGN_Z, REG_DOM_X, REG_DOM_Y, REG_DOM_Z,
        REG_BINS, REG_GEOM
    } t_reg_idx;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {MUL_LIN, MUL_RAD, MUL_DY, MUL_DZ, MUL_ANG} t_mul_sel;
    typedef enum logic [1:0] {DIV_WRAP, DIV_LIN, DIV_RAD} t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE, S_WRAP_CHK, S_WRAP_WAIT, S_CLASSIFY, S_SQ_DY, S_SQ_DZ,
        S_SQRT_GO, S_SQRT_WAIT, S_CYL_CHK, S_LIN_MUL, S_LIN_GO, S_LIN_WAIT,
        S_RAD_MUL, S_RAD_GO, S_RAD_WAIT, S_CORDIC_GO, S_CORDIC_WAIT,
        S_ANG_MUL, S_ANG_STORE, S_FINISH
    } t_state;

    typedef struct packed {
        logic       load;
        logic       div_start;
        t_div_sel   div_sel;
        logic       wrap_fix;
        logic       mul_en;
        t_mul_sel   mul_sel;
        logic       sqrt_start;
        logic       cordic_start;
        logic       bin_store;
        logic       bin_ang;
        logic       inside_set;
        logic       emit;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic cordic_done;
        logic need_wrap;
        logic cart_in;
        logic cyl_pre;
        logic r_in;
        logic dz_zero;
        logic cyl_mode;
        logic out_free;
    } t_status;

    // a count field of zero acts as one
    function automatic logic [BIN_INDEX_BITS-1:0] bin_n(input logic [BIN_INDEX_BITS-1:0] f);
        return (f == '0) ? BIN_INDEX_BITS'(1) : f;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/spatial_bin_index_mapper_core.sv
// Spatial bin index mapper: top level joining controller and datapath.
//
// Input channel (i_in_valid / o_in_ready) takes one particle position (i_pos_x,
// i_pos_y, i_pos_z, signed Q16.16). Output channel (o_out_valid / i_out_ready)
// gives o_in_region and three bin indices. The user must write registers over
// i_cfg_wr_en / i_cfg_index / i_cfg_data only while idle; this is not enforced.
//
// One request at a time. A shared restoring divider serves each periodic wrap
// that is needed and each linear or radial bin; a 32-step square root and a
// 20-step CORDIC serve cylinder mode. Each request first wraps the periodic
// axes that need it; a point found outside the region is then emitted
// without binning, and a cylinder point skips the CORDIC when dz is zero.
// The next request can be accepted in the cycle after a result is emitted.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block stalls at the end of that request until the
// receiver takes the earlier one. Synchronous reset clears the registers to
// their defaults (all bin counts one) and drops any pending result.
`default_nettype none

module spatial_bin_index_mapper_core import sbim_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_pos_y,
    input  wire logic signed [COORD_BITS-1:0] i_pos_z,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_in_region,
    output logic [BIN_INDEX_BITS-1:0]         o_bin_x,
    output logic [BIN_INDEX_BITS-1:0]         o_bin_y,
    output logic [BIN_INDEX_BITS-1:0]         o_bin_z
);

    t_cmd    cmd;
    t_status status;

    sbim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sbim_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_in_region (o_in_region),
        .o_bin_x     (o_bin_x),
        .o_bin_y     (o_bin_y),
        .o_bin_z     (o_bin_z)
    );

endmodule

`default_nettype wire

>>> hw/rtl/sbim_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module sbim_div import sbim_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [DIV_DVD_BITS-1:0] i_dividend,
    input  wire logic [COORD_BITS-1:0]   i_divisor,
    output logic                         o_done,
    output logic [DIV_DVD_BITS-1:0]      o_quotient,
    output logic [COORD_BITS-1:0]        o_remainder
);

    logic [DIV_DVD_BITS-1:0] r_quot;
    logic [COORD_BITS-1:0]   r_rem, r_dsr;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy, r_done;
    logic [COORD_BITS:0]     rem_sh, rem_sub;

    // trial subtract of the shifted partial remainder
    always_comb begin
        rem_sh  = {r_rem, r_quot[DIV_DVD_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_DVD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // hold operands and shift the quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            if (!rem_sub[COORD_BITS]) begin
                r_rem  <= rem_sub[COORD_BITS-1:0];
                r_quot <= {r_quot[DIV_DVD_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[COORD_BITS-1:0];
                r_quot <= {r_quot[DIV_DVD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> hw/rtl/sbim_dpath.sv
// Datapath: registers, position store, multiplier, square root, CORDIC and divider.
`default_nettype none

module sbim_dpath import sbim_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_pos_y,
    input  wire logic signed [COORD_BITS-1:0] i_pos_z,
    input  wire logic                        i_out_ready,
    input  wire t_cmd                        i_cmd,
    output t_status                          o_status,
    output logic                             o_out_valid,
    output logic                             o_in_region,
    output logic [BIN_INDEX_BITS-1:0]        o_bin_x,
    output logic [BIN_INDEX_BITS-1:0]        o_bin_y,
    output logic [BIN_INDEX_BITS-1:0]        o_bin_z
);

    logic signed [COORD_BITS-1:0] r_rgn_lo [3];
    logic signed [COORD_BITS-1:0] r_rgn_hi [3];
    logic signed [COORD_BITS-1:0] r_dom_lo [3];
    logic signed [COORD_BITS-1:0] r_dom_hi [3];
    logic [3*BIN_INDEX_BITS-1:0]  r_bins;
    logic [3:0]                   r_geom;

    logic signed [COORD_BITS-1:0] r_pos [3];
    logic [BIN_INDEX_BITS-1:0]    r_bin [3];
    logic                         r_inside;
    logic [2*COORD_BITS-1:0]      r_prod, r_sq_acc;

    logic [2*COORD_BITS-1:0]      r_sq_val;
    logic [COORD_BITS+1:0]        r_sq_rem;
    logic [COORD_BITS-1:0]        r_root;
    logic [SQRT_CNT_BITS-1:0]     r_sq_cnt;
    logic                         r_sq_busy, r_sq_done;

    logic signed [CD_W-1:0]       r_cx, r_cy;
    logic signed [ACC_W-1:0]      r_acc;
    logic [CD_CNT_BITS-1:0]       r_cd_cnt;
    logic                         r_cd_busy, r_cd_done;

    logic                         r_out_valid, r_out_in;
    logic [BIN_INDEX_BITS-1:0]    r_out_bin [3];

    logic [BIN_INDEX_BITS-1:0]    n_eff [3];
    logic signed [COORD_BITS-1:0] c_cur, dlo, dhi, rlo, rhi;
    logic [BIN_INDEX_BITS-1:0]    n_cur;
    logic                         per_cur;
    logic signed [COORD_BITS:0]   dom_diff, dom_span, rgn_diff, rgn_span;
    logic [COORD_BITS-1:0]        wrap_mag;
    logic signed [COORD_BITS:0]   dy, dz, yhi_ext, neg_yhi;
    logic [COORD_BITS-1:0]        dy_mag, dz_mag, turn;
    logic signed [ACC_W-1:0]      acc_cl;
    logic [COORD_BITS-1:0]        mul_a, mul_b;
    logic [2*COORD_BITS-1:0]      mul_p;
    logic [DIV_DVD_BITS-1:0]      div_dvd, div_quot, bin_src, bin_nm1;
    logic [COORD_BITS-1:0]        div_dsr;
    logic                         div_done;
    logic [COORD_BITS+1:0]        sq_sh, sq_trial, sq_sub;
    logic signed [CD_W-1:0]       cd_sx, cd_sy;
    logic [31:0]                  cd_ang;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_rgn_lo[i] <= '0;
                r_rgn_hi[i] <= '0;
                r_dom_lo[i] <= '0;
                r_dom_hi[i] <= '0;
            end
            r_bins <= BINS_RESET;
            r_geom <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_RGN_X: begin
                    r_rgn_lo[0] <= i_cfg_data[31:0];
                    r_rgn_hi[0] <= i_cfg_data[63:32];
                end
                REG_RGN_Y: begin
                    r_rgn_lo[1] <= i_cfg_data[31:0];
                    r_rgn_hi[1] <= i_cfg_data[63:32];
                end
                REG_RGN_Z: begin
                    r_rgn_lo[2] <= i_cfg_data[31:0];
                    r_rgn_hi[2] <= i_cfg_data[63:32];
                end
                REG_DOM_X: begin
                    r_dom_lo[0] <= i_cfg_data[31:0];
                    r_dom_hi[0] <= i_cfg_data[63:32];
                end
                REG_DOM_Y: begin
                    r_dom_lo[1] <= i_cfg_data[31:0];
                    r_dom_hi[1] <= i_cfg_data[63:32];
                end
                REG_DOM_Z: begin
                    r_dom_lo[2] <= i_cfg_data[31:0];
                    r_dom_hi[2] <= i_cfg_data[63:32];
                end
                REG_BINS:  r_bins <= i_cfg_data[3*BIN_INDEX_BITS-1:0];
                REG_GEOM:  r_geom <= i_cfg_data[3:0];
                default:   ;
            endcase
        end
    end

    // select the working axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_eff[i] = bin_n(r_bins[i*BIN_INDEX_BITS +: BIN_INDEX_BITS]);
        end
        case (i_cmd.axis)
            AXIS_Y: begin
                c_cur = r_pos[1]; dlo = r_dom_lo[1]; dhi = r_dom_hi[1];
                rlo = r_rgn_lo[1]; rhi = r_rgn_hi[1]; n_cur = n_eff[1]; per_cur = r_geom[1];
            end
            AXIS_Z: begin
                c_cur = r_pos[2]; dlo = r_dom_lo[2]; dhi = r_dom_hi[2];
                rlo = r_rgn_lo[2]; rhi = r_rgn_hi[2]; n_cur = n_eff[2]; per_cur = r_geom[2];
            end
            default: begin
                c_cur = r_pos[0]; dlo = r_dom_lo[0]; dhi = r_dom_hi[0];
                rlo = r_rgn_lo[0]; rhi = r_rgn_hi[0]; n_cur = n_eff[0]; per_cur = r_geom[0];
            end
        endcase
    end

    // periodic wrap and linear bin operands
    always_comb begin
        dom_diff = {c_cur[COORD_BITS-1], c_cur} - {dlo[COORD_BITS-1], dlo};
        dom_span = {dhi[COORD_BITS-1], dhi} - {dlo[COORD_BITS-1], dlo};
        rgn_diff = {c_cur[COORD_BITS-1], c_cur} - {rlo[COORD_BITS-1], rlo};
        rgn_span = {rhi[COORD_BITS-1], rhi} - {rlo[COORD_BITS-1], rlo};
        wrap_mag = dom_diff[COORD_BITS] ? COORD_BITS'(-dom_diff) : dom_diff[COORD_BITS-1:0];
    end

    // cylinder offsets and angle result
    always_comb begin
        dy      = {r_pos[1][COORD_BITS-1], r_pos[1]} - {r_rgn_lo[1][COORD_BITS-1], r_rgn_lo[1]};
        dz      = {r_pos[2][COORD_BITS-1], r_pos[2]} - {r_rgn_lo[2][COORD_BITS-1], r_rgn_lo[2]};
        yhi_ext = {r_rgn_hi[1][COORD_BITS-1], r_rgn_hi[1]};
        neg_yhi = -yhi_ext;
        dy_mag  = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        dz_mag  = dz[COORD_BITS] ? COORD_BITS'(-dz) : dz[COORD_BITS-1:0];
        if (r_acc < $signed(ACC_W'(1))) begin
            acc_cl = ACC_W'(1);
        end else if (r_acc > $signed(ACC_W'(32'h7FFF_FFFF))) begin
            acc_cl = ACC_W'(32'h7FFF_FFFF);
        end else begin
            acc_cl = r_acc;
        end
        if (dz == '0) begin
            turn = dy[COORD_BITS] ? 32'h8000_0000 : '0;
        end else if (dz[COORD_BITS]) begin
            turn = COORD_BITS'(-acc_cl);
        end else begin
            turn = acc_cl[COORD_BITS-1:0];
        end
    end

    // status toward the controller
    always_comb begin
        o_status.div_done    = div_done;
        o_status.sqrt_done   = r_sq_done;
        o_status.cordic_done = r_cd_done;
        o_status.need_wrap   = per_cur && (dlo < dhi) && ((c_cur < dlo) || (c_cur >= dhi));
        o_status.cart_in     = (r_pos[0] >= r_rgn_lo[0]) && (r_pos[0] < r_rgn_hi[0])
                            && (r_pos[1] >= r_rgn_lo[1]) && (r_pos[1] < r_rgn_hi[1])
                            && (r_pos[2] >= r_rgn_lo[2]) && (r_pos[2] < r_rgn_hi[2]);
        o_status.cyl_pre     = (r_pos[0] >= r_rgn_lo[0]) && (r_pos[0] < r_rgn_hi[0])
                            && (r_rgn_hi[1] > 0)
                            && (dy > neg_yhi) && (dy < yhi_ext)
                            && (dz > neg_yhi) && (dz < yhi_ext);
        o_status.r_in        = r_root < r_rgn_hi[1][COORD_BITS-1:0];
        o_status.dz_zero     = (dz == '0);
        o_status.cyl_mode    = r_geom[3];
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LIN: begin mul_a = rgn_diff[COORD_BITS-1:0]; mul_b = COORD_BITS'(n_cur); end
            MUL_RAD: begin mul_a = r_root;                   mul_b = COORD_BITS'(n_cur); end
            MUL_DY:  begin mul_a = dy_mag;                   mul_b = dy_mag;             end
            MUL_DZ:  begin mul_a = dz_mag;                   mul_b = dz_mag;             end
            MUL_ANG: begin mul_a = turn;                     mul_b = COORD_BITS'(n_cur); end
            default: begin mul_a = '0;                       mul_b = '0;                 end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel == MUL_DY) begin
                r_sq_acc <= mul_p;
            end else begin
                r_prod <= mul_p;
            end
        end
    end

    // divider operands
    always_comb begin
        case (i_cmd.div_sel)
            DIV_WRAP: begin div_dvd = DIV_DVD_BITS'(wrap_mag); div_dsr = dom_span[COORD_BITS-1:0]; end
            DIV_LIN:  begin div_dvd = r_prod[DIV_DVD_BITS-1:0]; div_dsr = rgn_span[COORD_BITS-1:0]; end
            DIV_RAD:  begin div_dvd = r_prod[DIV_DVD_BITS-1:0]; div_dsr = r_rgn_hi[1]; end
            default:  begin div_dvd = '0;                       div_dsr = '0; end
        endcase
    end

    logic [COORD_BITS-1:0] div_rem_raw;

    sbim_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dsr),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem_raw)
    );

    // bin value with clamp to n - 1, and the wrapped coordinate
    logic [BIN_INDEX_BITS-1:0] bin_val;
    logic [COORD_BITS-1:0]     wrap_new;
    always_comb begin
        bin_src = i_cmd.bin_ang ? DIV_DVD_BITS'(r_prod[2*COORD_BITS-1:COORD_BITS]) : div_quot;
        bin_nm1 = DIV_DVD_BITS'(n_cur - 1'b1);
        bin_val = (bin_src > bin_nm1) ? bin_nm1[BIN_INDEX_BITS-1:0]
                                      : bin_src[BIN_INDEX_BITS-1:0];
        wrap_new = (dom_diff[COORD_BITS] && (div_rem_raw != '0))
                 ? dom_span[COORD_BITS-1:0] - div_rem_raw : div_rem_raw;
        wrap_new = dlo + wrap_new;
    end

    // position, bins and region flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            for (int i = 0; i < 3; i++) begin
                r_bin[i] <= '0;
            end
            r_inside <= 1'b0;
        end else begin
            if (i_cmd.wrap_fix) begin
                case (i_cmd.axis)
                    AXIS_Y:  r_pos[1] <= wrap_new;
                    AXIS_Z:  r_pos[2] <= wrap_new;
                    default: r_pos[0] <= wrap_new;
                endcase
            end
            if (i_cmd.bin_store) begin
                case (i_cmd.axis)
                    AXIS_Y:  r_bin[1] <= bin_val;
                    AXIS_Z:  r_bin[2] <= bin_val;
                    default: r_bin[0] <= bin_val;
                endcase
            end
            if (i_cmd.inside_set) begin
                r_inside <= 1'b1;
            end
        end
    end

    // integer square root, one result bit per cycle
    always_comb begin
        sq_sh    = {r_sq_rem[COORD_BITS-1:0], r_sq_val[2*COORD_BITS-1 -: 2]};
        sq_trial = {r_root, 2'b01};
        sq_sub   = sq_sh - sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
            r_sq_cnt  <= '0;
        end else begin
            r_sq_done <= 1'b0;
            if (i_cmd.sqrt_start) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= '0;
            end else if (r_sq_busy) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
                if (r_sq_cnt == SQRT_CNT_BITS'(COORD_BITS - 1)) begin
                    r_sq_busy <= 1'b0;
                    r_sq_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_sq_val <= r_sq_acc + r_prod;
            r_sq_rem <= '0;
            r_root   <= '0;
        end else if (r_sq_busy) begin
            r_sq_val <= {r_sq_val[2*COORD_BITS-3:0], 2'b00};
            if (sq_sh >= sq_trial) begin
                r_sq_rem <= sq_sub;
                r_root   <= {r_root[COORD_BITS-2:0], 1'b1};
            end else begin
                r_sq_rem <= sq_sh;
                r_root   <= {r_root[COORD_BITS-2:0], 1'b0};
            end
        end
    end

    // vectoring CORDIC, one rotation per cycle
    always_comb begin
        cd_sx  = r_cx >>> r_cd_cnt;
        cd_sy  = r_cy >>> r_cd_cnt;
        cd_ang = ATAN_TURNS[5'(r_cd_cnt)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_busy <= 1'b0;
            r_cd_done <= 1'b0;
            r_cd_cnt  <= '0;
        end else begin
            r_cd_done <= 1'b0;
            if (i_cmd.cordic_start) begin
                r_cd_busy <= 1'b1;
                r_cd_cnt  <= '0;
            end else if (r_cd_busy) begin
                r_cd_cnt <= r_cd_cnt + 1'b1;
                if (r_cd_cnt == CD_CNT_BITS'(CORDIC_ITERATIONS - 1)) begin
                    r_cd_busy <= 1'b0;
                    r_cd_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_start) begin
            if (dy[COORD_BITS]) begin
                r_cx  <= CD_W'(dz_mag);
                r_cy  <= CD_W'(dy_mag);
                r_acc <= ACC_W'(32'h4000_0000);
            end else begin
                r_cx  <= CD_W'(dy_mag);
                r_cy  <= CD_W'(dz_mag);
                r_acc <= '0;
            end
        end else if (r_cd_busy) begin
            if (r_cy > 0) begin
                r_cx  <= r_cx + cd_sy;
                r_cy  <= r_cy - cd_sx;
                r_acc <= r_acc + ACC_W'(cd_ang);
            end else begin
                r_cx  <= r_cx - cd_sy;
                r_cy  <= r_cy + cd_sx;
                r_acc <= r_acc - ACC_W'(cd_ang);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_in <= r_inside;
            for (int i = 0; i < 3; i++) begin
                r_out_bin[i] <= r_bin[i];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_in_region = r_out_in;
    assign o_bin_x     = r_out_bin[0];
    assign o_bin_y     = r_out_bin[1];
    assign o_bin_z     = r_out_bin[2];

endmodule

`default_nettype wire

>>> hw/rtl/sbim_ctrl.sv
// Controller state machine sequencing wrap, binning, root and angle steps.
`default_nettype none

module sbim_ctrl import sbim_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AXIS_X;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_WRAP_CHK;
                    n_axis  = AXIS_X;
                end
            end
            S_WRAP_CHK, S_WRAP_WAIT: begin
                if ((r_state == S_WRAP_CHK && !i_status.need_wrap)
                    || (r_state == S_WRAP_WAIT && i_status.div_done)) begin
                    if (r_axis == AXIS_Z) begin
                        n_state = S_CLASSIFY;
                        n_axis  = AXIS_X;
                    end else begin
                        n_state = S_WRAP_CHK;
                        n_axis  = r_axis + 1'b1;
                    end
                end else if (r_state == S_WRAP_CHK) begin
                    n_state = S_WRAP_WAIT;
                end
            end
            S_CLASSIFY: begin
                if (i_status.cyl_mode) begin
                    n_state = i_status.cyl_pre ? S_SQ_DY : S_FINISH;
                end else begin
                    n_state = i_status.cart_in ? S_LIN_MUL : S_FINISH;
                end
            end
            S_SQ_DY:   n_state = S_SQ_DZ;
            S_SQ_DZ:   n_state = S_SQRT_GO;
            S_SQRT_GO: n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: begin
                if (i_status.sqrt_done) begin
                    n_state = S_CYL_CHK;
                end
            end
            S_CYL_CHK: begin
                n_state = i_status.r_in ? S_LIN_MUL : S_FINISH;
                n_axis  = AXIS_X;
            end
            S_LIN_MUL: n_state = S_LIN_GO;
            S_LIN_GO:  n_state = S_LIN_WAIT;
            S_LIN_WAIT: begin
                if (i_status.div_done) begin
                    if (i_status.cyl_mode) begin
                        n_state = S_RAD_MUL;
                        n_axis  = AXIS_Y;
                    end else if (r_axis == AXIS_Z) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_LIN_MUL;
                        n_axis  = r_axis + 1'b1;
                    end
                end
            end
            S_RAD_MUL: n_state = S_RAD_GO;
            S_RAD_GO:  n_state = S_RAD_WAIT;
            S_RAD_WAIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.dz_zero ? S_ANG_MUL : S_CORDIC_GO;
                    n_axis  = AXIS_Z;
                end
            end
            S_CORDIC_GO: n_state = S_CORDIC_WAIT;
            S_CORDIC_WAIT: begin
                if (i_status.cordic_done) begin
                    n_state = S_ANG_MUL;
                end
            end
            S_ANG_MUL:   n_state = S_ANG_STORE;
            S_ANG_STORE: n_state = S_FINISH;
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_WRAP_CHK: begin
                o_cmd.div_sel   = DIV_WRAP;
                o_cmd.div_start = i_status.need_wrap;
            end
            S_WRAP_WAIT: begin
                o_cmd.div_sel  = DIV_WRAP;
                o_cmd.wrap_fix = i_status.div_done;
            end
            S_CLASSIFY: o_cmd.inside_set = !i_status.cyl_mode && i_status.cart_in;
            S_SQ_DY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DY;
            end
            S_SQ_DZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DZ;
            end
            S_SQRT_GO: o_cmd.sqrt_start = 1'b1;
            S_CYL_CHK: o_cmd.inside_set = i_status.r_in;
            S_LIN_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LIN;
            end
            S_LIN_GO: begin
                o_cmd.div_sel   = DIV_LIN;
                o_cmd.div_start = 1'b1;
            end
            S_LIN_WAIT: o_cmd.bin_store = i_status.div_done;
            S_RAD_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RAD;
            end
            S_RAD_GO: begin
                o_cmd.div_sel   = DIV_RAD;
                o_cmd.div_start = 1'b1;
            end
            S_RAD_WAIT:  o_cmd.bin_store = i_status.div_done;
            S_CORDIC_GO: o_cmd.cordic_start = 1'b1;
            S_ANG_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ANG;
            end
            S_ANG_STORE: begin
                o_cmd.bin_store = 1'b1;
                o_cmd.bin_ang   = 1'b1;
            end
            S_FINISH: o_cmd.emit = i_status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire
